@@ rtl/etfk_pkg.sv @@
// Shared types, constants and register codes of the escape-time fractal kernel.
package etfk_pkg;

  localparam int unsigned FRAC_BITS_DEF = 27;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned PROD_W        = 2 * COORD_W;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned GLYPH_W       = 9;

  // Multiply, scale, add c, square and compare: one lap of the ring per iteration.
  localparam int unsigned RING_DEPTH    = 5;
  localparam int unsigned TAG_W         = $clog2(RING_DEPTH) + 1;

  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRACTAL_MODE    = 3'd0,
    CFG_ITERATION_LIMIT = 3'd1,
    CFG_JULIA_C_REAL    = 3'd2,
    CFG_JULIA_C_IMAG    = 3'd3,
    CFG_GLYPH_OFFSET    = 3'd4
  } cfg_index_t;

  localparam logic               FRACTAL_MODE_RST    = 1'b0;
  localparam logic [COUNT_W-1:0] ITERATION_LIMIT_RST = 8'd32;
  localparam coord_t             JULIA_C_REAL_RST    = -32'sd335544320;
  localparam coord_t             JULIA_C_IMAG_RST    = 32'sd44829000;
  localparam logic [COUNT_W-1:0] GLYPH_OFFSET_RST    = 8'd32;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_real;
    logic signed [COORD_W-1:0] point_imag;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
    logic               trapped;
    logic [GLYPH_W-1:0] glyph_code;
  } out_item_t;

  // Control that travels with each point around the iteration ring.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic               escaped;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
  } iter_ctl_t;

endpackage

@@ rtl/escape_time_fractal_kernel_top.sv @@
// Top level of the escape-time fractal kernel: ring control, registers and ports.
//
// Each point iterates z = z*z + c in signed fixed point (FRAC_BITS fraction bits)
// on a ring of five register stages: products, floor scaling, add c, squares and
// the |z|^2 > 4 test. One lap of the ring is one iteration, so a point that runs
// n iterations makes at least n laps (at least one when the limit is zero),
// and up to five points share the ring at once, entering back to back whenever a
// ring slot passes the entry point empty. With the five slots busy, throughput
// falls as the iteration limit (32 at reset) rises, as it is set by the single
// shared iteration datapath. Results leave strictly in input order: a finished
// point keeps circling until every older point has left, then moves into the
// output register, which holds it while out_stall is high without blocking the
// ring. Configuration writes take effect at once (cfg_ready is always high) and
// belong in idle periods with no points in flight.
module escape_time_fractal_kernel_top import etfk_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int unsigned ZW_W = PROD_W + 2 - FRAC_BITS;

  // Configuration registers.
  logic               mode_r;
  logic [COUNT_W-1:0] limit_r;
  coord_t             jcr_r, jci_r;
  logic [COUNT_W-1:0] offset_r;

  // Ring wiring.
  iter_ctl_t                head_ctl, s1_ctl, s3_ctl, tail_ctl;
  coord_t                   head_zr, head_zi, head_cr, head_ci;
  coord_t                   s1_cr, s1_ci, s3_cr, s3_ci;
  coord_t                   tail_zr, tail_zi, tail_cr, tail_ci;
  logic signed [PROD_W-1:0] s1_prr, s1_pii, s1_pri;
  logic signed [ZW_W-1:0]   s3_zrw, s3_ziw;

  // Ordering and output.
  logic [TAG_W-1:0] in_tag_r, out_tag_r;
  logic             ring_exit, slot_free, in_accept, out_free;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  // Decode the register index; ignore writes past the last register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= FRACTAL_MODE_RST;
      limit_r  <= ITERATION_LIMIT_RST;
      jcr_r    <= JULIA_C_REAL_RST;
      jci_r    <= JULIA_C_IMAG_RST;
      offset_r <= GLYPH_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRACTAL_MODE:    mode_r   <= cfg_wdata[0];
        CFG_ITERATION_LIMIT: limit_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_JULIA_C_REAL:    jcr_r    <= cfg_wdata[COORD_W-1:0];
        CFG_JULIA_C_IMAG:    jci_r    <= cfg_wdata[COORD_W-1:0];
        CFG_GLYPH_OFFSET:    offset_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Retire the tail point only if it is finished, is the oldest in flight and
  // the output register can take it; otherwise send it around again.
  assign out_free  = !out_valid_r || !out_stall;
  assign ring_exit = tail_ctl.valid && tail_ctl.done && (tail_ctl.tag == out_tag_r) && out_free;
  assign slot_free = !tail_ctl.valid || ring_exit;
  assign in_stall  = !slot_free;
  assign in_accept = in_valid && slot_free;

  // Fill the head slot: a new transaction, the recirculated tail, or a bubble.
  always_comb begin
    head_ctl       = tail_ctl;
    head_ctl.valid = tail_ctl.valid && !ring_exit;
    head_zr        = tail_zr;
    head_zi        = tail_zi;
    head_cr        = tail_cr;
    head_ci        = tail_ci;
    if (in_accept) begin
      head_ctl.valid   = 1'b1;
      head_ctl.done    = (limit_r == '0);
      head_ctl.escaped = 1'b0;
      head_ctl.tag     = in_tag_r;
      head_ctl.count   = '0;
      if (mode_r) begin
        // Mandelbrot: z starts at zero, the point is c.
        head_zr = '0;
        head_zi = '0;
        head_cr = in_data.point_real;
        head_ci = in_data.point_imag;
      end else begin
        // Julia: z starts at the point, c comes from the registers.
        head_zr = in_data.point_real;
        head_zi = in_data.point_imag;
        head_cr = jcr_r;
        head_ci = jci_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r  <= '0;
      out_tag_r <= '0;
    end else begin
      if (in_accept) begin
        in_tag_r <= in_tag_r + TAG_W'(1);
      end
      if (ring_exit) begin
        out_tag_r <= out_tag_r + TAG_W'(1);
      end
    end
  end

  etfk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (head_ctl),
    .zr_i  (head_zr),
    .zi_i  (head_zi),
    .cr_i  (head_cr),
    .ci_i  (head_ci),
    .ctl_o (s1_ctl),
    .cr_o  (s1_cr),
    .ci_o  (s1_ci),
    .prr_o (s1_prr),
    .pii_o (s1_pii),
    .pri_o (s1_pri)
  );

  etfk_fold #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (s1_ctl),
    .cr_i  (s1_cr),
    .ci_i  (s1_ci),
    .prr_i (s1_prr),
    .pii_i (s1_pii),
    .pri_i (s1_pri),
    .ctl_o (s3_ctl),
    .cr_o  (s3_cr),
    .ci_o  (s3_ci),
    .zrw_o (s3_zrw),
    .ziw_o (s3_ziw)
  );

  etfk_bound #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bound (
    .clk     (clk),
    .rst_n   (rst_n),
    .limit_i (limit_r),
    .ctl_i   (s3_ctl),
    .cr_i    (s3_cr),
    .ci_i    (s3_ci),
    .zrw_i   (s3_zrw),
    .ziw_i   (s3_ziw),
    .ctl_o   (tail_ctl),
    .zr_o    (tail_zr),
    .zi_o    (tail_zi),
    .cr_o    (tail_cr),
    .ci_o    (tail_ci)
  );

  // Output register: load on retire, drop once the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ring_exit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    out_data_nxt.escape_count = tail_ctl.count;
    out_data_nxt.trapped      = !tail_ctl.escaped;
    out_data_nxt.glyph_code   = GLYPH_W'(tail_ctl.count) + GLYPH_W'(offset_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_exit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Points in the ring never outnumber its slots.
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (TAG_W'(in_tag_r - out_tag_r) <= TAG_W'(RING_DEPTH)))
    else $error("more points in flight than ring slots");

  // With every accepted point retired, the ring tail holds nothing.
  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tag_r == out_tag_r) |-> !tail_ctl.valid)
    else $error("valid point in ring with no transaction outstanding");

  // An escaped point must have stopped iterating.
  a_escape_done: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_ctl.valid && tail_ctl.escaped) |-> tail_ctl.done)
    else $error("escaped point still marked as iterating");

  // A retired point always lands in the output register.
  a_exit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ring_exit |=> (out_valid_r && (out_data_r.escape_count == $past(tail_ctl.count))))
    else $error("retired point not presented at the output");

endmodule

@@ rtl/etfk_mul.sv @@
// Ring stage one: the three full-width products of the complex square.
module etfk_mul import etfk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iter_ctl_t                ctl_i,
  input  coord_t                   zr_i,
  input  coord_t                   zi_i,
  input  coord_t                   cr_i,
  input  coord_t                   ci_i,
  output iter_ctl_t                ctl_o,
  output coord_t                   cr_o,
  output coord_t                   ci_o,
  output logic signed [PROD_W-1:0] prr_o,
  output logic signed [PROD_W-1:0] pii_o,
  output logic signed [PROD_W-1:0] pri_o
);

  iter_ctl_t                ctl_r;
  coord_t                   cr_r, ci_r;
  logic signed [PROD_W-1:0] prr_r, pii_r, pri_r;
  logic signed [PROD_W-1:0] prr_nxt, pii_nxt, pri_nxt;

  always_comb begin
    prr_nxt = PROD_W'(zr_i) * PROD_W'(zr_i);
    pii_nxt = PROD_W'(zi_i) * PROD_W'(zi_i);
    pri_nxt = PROD_W'(zr_i) * PROD_W'(zi_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    cr_r  <= cr_i;
    ci_r  <= ci_i;
    prr_r <= prr_nxt;
    pii_r <= pii_nxt;
    pri_r <= pri_nxt;
  end

  assign ctl_o = ctl_r;
  assign cr_o  = cr_r;
  assign ci_o  = ci_r;
  assign prr_o = prr_r;
  assign pii_o = pii_r;
  assign pri_o = pri_r;

endmodule

@@ rtl/etfk_fold.sv @@
// Ring stages two and three: floor-scale the products, then add c.
module etfk_fold import etfk_pkg::*; #(
  parameter  int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned ZW_W      = PROD_W + 2 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iter_ctl_t                ctl_i,
  input  coord_t                   cr_i,
  input  coord_t                   ci_i,
  input  logic signed [PROD_W-1:0] prr_i,
  input  logic signed [PROD_W-1:0] pii_i,
  input  logic signed [PROD_W-1:0] pri_i,
  output iter_ctl_t                ctl_o,
  output coord_t                   cr_o,
  output coord_t                   ci_o,
  output logic signed [ZW_W-1:0]   zrw_o,
  output logic signed [ZW_W-1:0]   ziw_o
);

  iter_ctl_t                ctl2_r, ctl3_r;
  coord_t                   cr2_r, ci2_r, cr3_r, ci3_r;
  logic signed [PROD_W-1:0] diff;
  logic signed [ZW_W-1:0]   sr_nxt, si_nxt, sr_r, si_r;
  logic signed [ZW_W-1:0]   zrw_nxt, ziw_nxt, zrw_r, ziw_r;

  // Arithmetic right shift of a signed value rounds toward minus infinity.
  always_comb begin
    diff   = prr_i - pii_i;
    sr_nxt = ZW_W'(diff >>> FRAC_BITS);
    si_nxt = ZW_W'(pri_i >>> (FRAC_BITS - 1));
  end

  always_comb begin
    zrw_nxt = sr_r + ZW_W'(cr2_r);
    ziw_nxt = si_r + ZW_W'(ci2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl2_r <= ctl_i;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    cr2_r <= cr_i;
    ci2_r <= ci_i;
    sr_r  <= sr_nxt;
    si_r  <= si_nxt;
    cr3_r <= cr2_r;
    ci3_r <= ci2_r;
    zrw_r <= zrw_nxt;
    ziw_r <= ziw_nxt;
  end

  assign ctl_o = ctl3_r;
  assign cr_o  = cr3_r;
  assign ci_o  = ci3_r;
  assign zrw_o = zrw_r;
  assign ziw_o = ziw_r;

endmodule

@@ rtl/etfk_bound.sv @@
// Ring stages four and five: escape test on |z|^2 and per-point count update.
module etfk_bound import etfk_pkg::*; #(
  parameter  int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned ZW_W      = PROD_W + 2 - FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COUNT_W-1:0]     limit_i,
  input  iter_ctl_t              ctl_i,
  input  coord_t                 cr_i,
  input  coord_t                 ci_i,
  input  logic signed [ZW_W-1:0] zrw_i,
  input  logic signed [ZW_W-1:0] ziw_i,
  output iter_ctl_t              ctl_o,
  output coord_t                 zr_o,
  output coord_t                 zi_o,
  output coord_t                 cr_o,
  output coord_t                 ci_o
);

  // A component within the bound fits ZT_W signed bits.
  localparam int unsigned ZT_W  = FRAC_BITS + 3;
  localparam int unsigned SQ_W  = 2 * ZT_W;
  localparam int unsigned MAG_W = SQ_W + 1;
  localparam logic signed [ZW_W-1:0] LIM     = ZW_W'(2) << FRAC_BITS;
  localparam logic signed [ZW_W-1:0] NEG_LIM = -LIM;
  localparam logic [MAG_W-1:0]       MAG_LIM = MAG_W'(1) << (2 * FRAC_BITS + 2);

  iter_ctl_t                ctl4_r, ctl5_r, ctl5_nxt;
  coord_t                   cr4_r, ci4_r, zr4_r, zi4_r;
  coord_t                   cr5_r, ci5_r, zr5_r, zi5_r;
  logic signed [ZT_W-1:0]   zrt, zit;
  logic signed [SQ_W-1:0]   sqr_nxt, sqi_nxt;
  logic [SQ_W-1:0]          sqr_r, sqi_r;
  logic                     big_nxt, big_r;
  logic [MAG_W-1:0]         mag;
  logic                     esc;
  logic [COUNT_W:0]         cnt_inc;

  // Square the truncated components; a component out of range escapes anyway.
  always_comb begin
    zrt     = $signed(zrw_i[ZT_W-1:0]);
    zit     = $signed(ziw_i[ZT_W-1:0]);
    sqr_nxt = SQ_W'(zrt) * SQ_W'(zrt);
    sqi_nxt = SQ_W'(zit) * SQ_W'(zit);
    big_nxt = (zrw_i > LIM) || (zrw_i < NEG_LIM) || (ziw_i > LIM) || (ziw_i < NEG_LIM);
  end

  always_comb begin
    mag     = MAG_W'(sqr_r) + MAG_W'(sqi_r);
    esc     = big_r || (mag > MAG_LIM);
    cnt_inc = {1'b0, ctl4_r.count} + (COUNT_W + 1)'(1);
    ctl5_nxt = ctl4_r;
    if (ctl4_r.valid && !ctl4_r.done) begin
      if (esc) begin
        ctl5_nxt.done    = 1'b1;
        ctl5_nxt.escaped = 1'b1;
      end else begin
        ctl5_nxt.count = cnt_inc[COUNT_W-1:0];
        if (cnt_inc == {1'b0, limit_i}) begin
          ctl5_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl4_r <= ctl_i;
      ctl5_r <= ctl5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr4_r <= cr_i;
    ci4_r <= ci_i;
    zr4_r <= zrw_i[COORD_W-1:0];
    zi4_r <= ziw_i[COORD_W-1:0];
    sqr_r <= sqr_nxt;
    sqi_r <= sqi_nxt;
    big_r <= big_nxt;
    cr5_r <= cr4_r;
    ci5_r <= ci4_r;
    zr5_r <= zr4_r;
    zi5_r <= zi4_r;
  end

  assign ctl_o = ctl5_r;
  assign zr_o  = zr5_r;
  assign zi_o  = zi5_r;
  assign cr_o  = cr5_r;
  assign ci_o  = ci5_r;

endmodule

@@ test/etfk_result_checker.sv @@
// Result checker for the escape-time fractal kernel: predicts each point and compares results.
`timescale 1ns / 1ps
module etfk_result_checker import etfk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    points_in_flight,
  output int unsigned           mismatch_count
);

  localparam int unsigned FRAC = FRAC_BITS_DEF;

  // Shadow copy of the register file.
  logic               mode_mandel;
  logic [COUNT_W-1:0] iter_limit;
  coord_t             c_real;
  coord_t             c_imag;
  logic [COUNT_W-1:0] glyph_base;

  out_item_t pending_results[$];
  out_item_t got;
  out_item_t want;

  // Run the escape-time iteration for one point under the shadow registers.
  function automatic out_item_t escape_time(input in_item_t pt);
    longint    zr, zi, cr, ci, sq_re, sq_im, bound, radius_sq;
    int        n;
    logic      escaped;
    out_item_t r;
    bound     = longint'(2) <<< FRAC;
    radius_sq = longint'(4) <<< (2 * FRAC);
    if (mode_mandel) begin
      zr = 0;
      zi = 0;
      cr = longint'($signed(pt.point_real));
      ci = longint'($signed(pt.point_imag));
    end else begin
      zr = longint'($signed(pt.point_real));
      zi = longint'($signed(pt.point_imag));
      cr = longint'(c_real);
      ci = longint'(c_imag);
    end
    n       = 0;
    escaped = 1'b0;
    while (n < int'(iter_limit) && !escaped) begin
      // Floor scaling: arithmetic shift of the exact product sums.
      sq_re = (zr * zr - zi * zi) >>> FRAC;
      sq_im = (zr * zi) >>> (FRAC - 1);
      zr    = sq_re + cr;
      zi    = sq_im + ci;
      if (zr > bound || zr < -bound || zi > bound || zi < -bound)
        escaped = 1'b1;
      else if (zr * zr + zi * zi > radius_sq)
        escaped = 1'b1;
      if (!escaped)
        n++;
    end
    r.escape_count = n[COUNT_W-1:0];
    r.trapped      = !escaped;
    r.glyph_code   = GLYPH_W'(n + int'(glyph_base));
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_mandel    <= FRACTAL_MODE_RST;
      iter_limit     <= ITERATION_LIMIT_RST;
      c_real         <= JULIA_C_REAL_RST;
      c_imag         <= JULIA_C_IMAG_RST;
      glyph_base     <= GLYPH_OFFSET_RST;
      pending_results.delete();
      points_in_flight <= 0;
      mismatch_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_FRACTAL_MODE:    mode_mandel <= cfg_wdata[0];
          CFG_ITERATION_LIMIT: iter_limit  <= cfg_wdata[COUNT_W-1:0];
          CFG_JULIA_C_REAL:    c_real      <= coord_t'(cfg_wdata);
          CFG_JULIA_C_IMAG:    c_imag      <= coord_t'(cfg_wdata);
          CFG_GLYPH_OFFSET:    glyph_base  <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          report($sformatf("result with no point outstanding: count %0d trapped %0d glyph %0d",
                           got.escape_count, got.trapped, got.glyph_code));
        end else begin
          want = pending_results.pop_front();
          if (got.escape_count !== want.escape_count)
            report($sformatf("escape_count got %0d expected %0d",
                             got.escape_count, want.escape_count));
          if (got.trapped !== want.trapped)
            report($sformatf("trapped got %0d expected %0d", got.trapped, want.trapped));
          if (got.glyph_code !== want.glyph_code)
            report($sformatf("glyph_code got %0d expected %0d",
                             got.glyph_code, want.glyph_code));
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(escape_time(in_data));
      points_in_flight <= pending_results.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the escape-time fractal kernel: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import etfk_pkg::*;

  localparam int FRAC            = FRAC_BITS_DEF;
  localparam int ONE_FX          = 1 << FRAC;
  localparam int TWO_FX          = 2 << FRAC;
  localparam int RAND_PHASES     = 15;
  localparam int ITEMS_PER_PHASE = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  int          points_in_flight;
  int unsigned mismatch_count;

  // Idle rates in percent, changed between phases.
  int unsigned send_idle_pct  = 25;
  int unsigned recv_stall_pct = 57;

  escape_time_fractal_kernel_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  etfk_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .points_in_flight (points_in_flight),
    .mismatch_count   (mismatch_count)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver back-pressure: stall at random with the current rate.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Build a point from two fixed-point coordinates.
  function automatic in_item_t pt(input coord_t re, input coord_t im);
    in_item_t p;
    p.point_real = re;
    p.point_imag = im;
    return p;
  endfunction

  // Uniform fixed-point value in [lo, hi].
  function automatic coord_t fx_between(input int lo, input int hi);
    return coord_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Mostly points in the interesting region, some on the escape-radius edge, some full range.
  function automatic in_item_t random_point();
    int unsigned kind;
    coord_t      a;
    coord_t      b;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      a = fx_between(-TWO_FX, TWO_FX);
      b = fx_between(-TWO_FX, TWO_FX);
    end else if (kind < 70) begin
      a = fx_between(-TWO_FX, ONE_FX / 2);
      b = fx_between(-(ONE_FX * 5 / 4), ONE_FX * 5 / 4);
    end else if (kind < 82) begin
      // Straddle the escape radius by a few LSBs on one axis.
      a = ($urandom_range(0, 1) ? TWO_FX : -TWO_FX) + int'($urandom_range(0, 8)) - 4;
      b = fx_between(-8, 8);
      if ($urandom_range(0, 1)) begin
        b = a;
        a = fx_between(-8, 8);
      end
    end else begin
      a = coord_t'($urandom());
      b = coord_t'($urandom());
    end
    return pt(a, b);
  endfunction

  // Present one register write and hold it until taken; caller drops cfg_valid.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all five registers back to back, with junk in the unused upper bits.
  task automatic program_settings(input logic mode, input logic [COUNT_W-1:0] limit,
                                  input coord_t c_re, input coord_t c_im,
                                  input logic [COUNT_W-1:0] offset);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    put_reg(CFG_FRACTAL_MODE, {junk[CFG_DATA_W-1:1], mode});
    junk = $urandom();
    put_reg(CFG_ITERATION_LIMIT, {junk[CFG_DATA_W-1:COUNT_W], limit});
    put_reg(CFG_JULIA_C_REAL, c_re);
    put_reg(CFG_JULIA_C_IMAG, c_im);
    junk = $urandom();
    put_reg(CFG_GLYPH_OFFSET, {junk[CFG_DATA_W-1:COUNT_W], offset});
    cfg_valid <= 1'b0;
  endtask

  // Send one point, idling at random first; hold the payload while stalled.
  task automatic send(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_in_flight != 0);
  endtask

  initial begin
    logic               mode_sel;
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] ofs;
    coord_t             cre;
    coord_t             cim;

    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings (Julia, limit 32), field extremes and the radius-2 boundary.
    send(pt(0, 0));
    send(pt(32'sh7fffffff, 32'sh7fffffff));
    send(pt(32'sh80000000, 32'sh80000000));
    send(pt(32'sh80000000, 32'sh7fffffff));
    send(pt(32'sh7fffffff, 32'sh80000000));
    send(pt(TWO_FX, 0));
    send(pt(TWO_FX + 1, 0));
    send(pt(-TWO_FX, -TWO_FX));
    send(pt(0, -TWO_FX - 1));
    send(pt(0, ONE_FX / 2));
    drain();

    // Unused register indexes: these writes must leave every setting unchanged.
    for (int idx = int'(CFG_GLYPH_OFFSET) + 1; idx < (1 << CFG_IDX_W); idx++)
      put_reg(idx[CFG_IDX_W-1:0], $urandom());
    cfg_valid <= 1'b0;
    send(pt(ONE_FX / 4, -ONE_FX / 4));
    drain();

    // Zero iteration limit: no step runs, count 0 and trapped.
    program_settings(1'b1, 8'd0, 32'sh7fffffff, 32'sh80000000, 8'd0);
    send(pt(0, 0));
    send(pt(32'sh7fffffff, 32'sh80000000));
    drain();

    // Deepest limit and largest offset: glyph reaches its top value.
    program_settings(1'b1, 8'd255, 32'sh80000000, 32'sh7fffffff, 8'd255);
    send(pt(0, 0));
    send(pt(-TWO_FX, 0));
    send(pt(ONE_FX / 4, 0));
    send(pt(ONE_FX / 4 + 1, 0));
    send(pt(TWO_FX, TWO_FX));
    send(pt(32'sh80000000, 32'sh7fffffff));
    drain();

    // Single step in Julia mode with c at zero.
    program_settings(1'b0, 8'd1, 0, 0, 8'd255);
    send(pt(TWO_FX, 0));
    send(pt(ONE_FX, ONE_FX));
    drain();

    // Random phases: fresh settings each time, idling pattern by thirds.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < RAND_PHASES / 3) begin
        send_idle_pct  = 25;
        recv_stall_pct = 57;
      end else if (ph < 2 * RAND_PHASES / 3) begin
        send_idle_pct  = 57;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      mode_sel = 1'($urandom_range(0, 1));
      case (ph % 8)
        3:       lim = 8'd255;
        6:       lim = 8'd0;
        1, 5:    lim = 8'd1;
        default: lim = COUNT_W'($urandom_range(2, 48));
      endcase
      if (ph % 4 == 0)
        ofs = (ph % 8 == 0) ? 8'd0 : 8'd255;
      else
        ofs = COUNT_W'($urandom_range(0, 255));
      cre = ($urandom_range(0, 4) == 0) ? coord_t'($urandom()) : fx_between(-ONE_FX, ONE_FX);
      cim = ($urandom_range(0, 4) == 0) ? coord_t'($urandom()) : fx_between(-ONE_FX, ONE_FX);
      program_settings(mode_sel, lim, cre, cim, ofs);
      repeat (ITEMS_PER_PHASE) send(random_point());
      drain();
    end

    // Let the ring settle past its five-stage lap before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && points_in_flight == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/etfk_pkg.sv
rtl/etfk_mul.sv
rtl/etfk_fold.sv
rtl/etfk_bound.sv
rtl/escape_time_fractal_kernel_top.sv
test/etfk_result_checker.sv
test/tb.sv
